// File: hw/rtl/bbwf_pkg.sv
// Shared types, constants and the arctangent table of the waypoint follower.
package bbwf_pkg;

   // Field widths
   localparam int POS_W     = 16;  // pose_x, pose_y (signed Q5.10)
   localparam int HEAD_W    = 15;  // pose_heading (signed Q2.12)
   localparam int DIFF_W    = 17;  // goal minus pose (signed Q6.10)
   localparam int VEC_W     = 32;  // rotation vector (difference scaled by 4096)
   localparam int ANG_W     = 25;  // accumulated angle (signed Q20)
   localparam int BEAR_W    = 17;  // bearing (signed Q4.12)
   localparam int HERR_W    = 18;  // bearing minus heading
   localparam int SQ_W      = 33;  // squared distance, Q13.20
   localparam int TOLSQ_W   = 30;  // squared tolerance, Q10.20
   localparam int ITER_W    = 5;   // rotation step index
   localparam int ATAN_W    = 20;  // arctangent table entry width
   localparam int ERR_W     = 15;  // saturated error outputs
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Angle and saturation constants
   localparam logic signed [ANG_W-1:0]  PI_Q20      = 25'sd3294199;
   localparam logic signed [ANG_W-1:0]  ROUND_Q8    = 25'sd128;
   localparam logic signed [HERR_W-1:0] PI_Q12      = 18'sd12868;
   localparam logic signed [HERR_W-1:0] TWO_PI_Q12  = 18'sd25736;
   localparam logic [ERR_W-1:0]         ERR_MAX     = 15'h7FFF;
   localparam logic [1:0]               GOAL_RESET  = 2'd1;

   // Register indexes (byte address divided by four)
   localparam logic [2:0] REG_CORNER_X    = 3'd0;
   localparam logic [2:0] REG_CORNER_Y    = 3'd1;
   localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
   localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_FWD_SPEED   = 3'd4;
   localparam logic [2:0] REG_TURN_SPEED  = 3'd5;
   localparam logic [2:0] REG_HEAD_TOL    = 3'd6;
   localparam logic [2:0] REG_POS_TOL     = 3'd7;

   // Register reset values
   localparam logic [3:0]  RST_CORNER_X    = 4'd1;
   localparam logic [3:0]  RST_CORNER_Y    = 4'd1;
   localparam logic [3:0]  RST_RECT_WIDTH  = 4'd4;
   localparam logic [3:0]  RST_RECT_HEIGHT = 4'd4;
   localparam logic [3:0]  RST_FWD_SPEED   = 4'd2;
   localparam logic [3:0]  RST_TURN_SPEED  = 4'd1;
   localparam logic [13:0] RST_HEAD_TOL    = 14'd717;
   localparam logic [14:0] RST_POS_TOL     = 15'd102;

   typedef struct packed {
      logic [3:0]  corner_x;
      logic [3:0]  corner_y;
      logic [3:0]  rect_width;
      logic [3:0]  rect_height;
      logic [3:0]  forward_speed;
      logic [3:0]  turn_speed;
      logic [13:0] heading_tolerance;
      logic [14:0] position_tolerance;
   } cfg_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROTATE,
      S_ANGLE,
      S_COMMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              load;    // capture an accepted transaction
      logic              rotate;  // one vectoring step
      logic [ITER_W-1:0] iter;    // current vectoring step
      logic              angle;   // form the heading error
      logic              commit;  // write the result and update goal state
   } cmd_type;

   // atan(2^-i) in Q20
   function automatic logic [ATAN_W-1:0] atan_q20(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:    v = 20'd823550;
         5'd1:    v = 20'd486170;
         5'd2:    v = 20'd256879;
         5'd3:    v = 20'd130396;
         5'd4:    v = 20'd65451;
         5'd5:    v = 20'd32757;
         5'd6:    v = 20'd16383;
         5'd7:    v = 20'd8192;
         5'd8:    v = 20'd4096;
         5'd9:    v = 20'd2048;
         5'd10:   v = 20'd1024;
         5'd11:   v = 20'd512;
         5'd12:   v = 20'd256;
         5'd13:   v = 20'd128;
         5'd14:   v = 20'd64;
         5'd15:   v = 20'd32;
         5'd16:   v = 20'd16;
         5'd17:   v = 20'd8;
         5'd18:   v = 20'd4;
         5'd19:   v = 20'd2;
         5'd20:   v = 20'd1;
         default: v = 20'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hw/rtl/bbwf_csr.sv
// Configuration register file with an APB-style access port.
module bbwf_csr
   import bbwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.corner_x           <= RST_CORNER_X;
         cfg_ff.corner_y           <= RST_CORNER_Y;
         cfg_ff.rect_width         <= RST_RECT_WIDTH;
         cfg_ff.rect_height        <= RST_RECT_HEIGHT;
         cfg_ff.forward_speed      <= RST_FWD_SPEED;
         cfg_ff.turn_speed         <= RST_TURN_SPEED;
         cfg_ff.heading_tolerance  <= RST_HEAD_TOL;
         cfg_ff.position_tolerance <= RST_POS_TOL;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_CORNER_X:    cfg_ff.corner_x           <= csr_pwdata[3:0];
            REG_CORNER_Y:    cfg_ff.corner_y           <= csr_pwdata[3:0];
            REG_RECT_WIDTH:  cfg_ff.rect_width         <= csr_pwdata[3:0];
            REG_RECT_HEIGHT: cfg_ff.rect_height        <= csr_pwdata[3:0];
            REG_FWD_SPEED:   cfg_ff.forward_speed      <= csr_pwdata[3:0];
            REG_TURN_SPEED:  cfg_ff.turn_speed         <= csr_pwdata[3:0];
            REG_HEAD_TOL:    cfg_ff.heading_tolerance  <= csr_pwdata[13:0];
            REG_POS_TOL:     cfg_ff.position_tolerance <= csr_pwdata[14:0];
            default:         ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_CORNER_X:    csr_prdata = {28'd0, cfg_ff.corner_x};
         REG_CORNER_Y:    csr_prdata = {28'd0, cfg_ff.corner_y};
         REG_RECT_WIDTH:  csr_prdata = {28'd0, cfg_ff.rect_width};
         REG_RECT_HEIGHT: csr_prdata = {28'd0, cfg_ff.rect_height};
         REG_FWD_SPEED:   csr_prdata = {28'd0, cfg_ff.forward_speed};
         REG_TURN_SPEED:  csr_prdata = {28'd0, cfg_ff.turn_speed};
         REG_HEAD_TOL:    csr_prdata = {18'd0, cfg_ff.heading_tolerance};
         REG_POS_TOL:     csr_prdata = {17'd0, cfg_ff.position_tolerance};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/bbwf_ctrl.sv
// Controller state machine: sequences load, vectoring steps, angle and commit.
module bbwf_ctrl
   import bbwf_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    restart_req,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ANGLE_ITERATIONS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire;
   logic              slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      cmd        = '0;
      cmd.iter   = iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               state_in = restart_req ? S_COMMIT : S_ROTATE;
            end
         end
         S_ROTATE: begin
            cmd.rotate = 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = S_ANGLE;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_ANGLE: begin
            cmd.angle = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // hold the result until the downstream side takes it
      rsp_valid_in = cmd.commit | (rsp_valid_ff & !rsp_tready);
   end

   a_commit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit while output register is still full");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   a_restart_skips_rotation: assert property (@(posedge clock) disable iff (reset)
      (req_fire && restart_req) |=> (state_ff == S_COMMIT))
      else $error("restart transaction did not go straight to commit");

   a_iter_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROTATE) |-> (iter_ff <= LAST_ITER))
      else $error("vectoring step index past the last step");

endmodule

// File: hw/rtl/bbwf_datapath.sv
// Datapath: goal differences, vectoring atan2, squared distance, decision and result register.
module bbwf_datapath
   import bbwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  cfg_type               cfg,
   input  logic                  req_action,
   input  logic [POS_W-1:0]      req_pose_x,
   input  logic [POS_W-1:0]      req_pose_y,
   input  logic [HEAD_W-1:0]     req_pose_heading,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // Persistent block state
   logic [1:0] goal_ff, goal_in;
   logic       started_ff, started_in;

   // Per-transaction working registers
   logic                     action_ff;
   logic                     zero_ff;
   logic                     start_hit_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [HEAD_W-1:0] ph_ff;
   logic signed [VEC_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0]  z_ff;
   logic signed [HERR_W-1:0] h_ff;
   logic [SQ_W-1:0]          prod_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [TOLSQ_W-1:0]       tolsq_ff;

   // Result register
   logic                 o_cmd_valid_ff, o_err_valid_ff, o_reached_ff;
   logic [3:0]           o_lin_ff;
   logic [4:0]           o_ang_ff;
   logic [ERR_W-1:0]     o_xerr_ff, o_yerr_ff, o_herr_ff;
   logic [1:0]           o_goal_ff;

   // ---------------- load: goal corner and differences
   logic [4:0]               gx_units, gy_units;
   logic signed [DIFF_W-1:0] dx_calc, dy_calc;
   logic signed [VEC_W-1:0]  x0, y0;
   logic                     start_hit;

   always_comb begin
      gx_units = {1'b0, cfg.corner_x} +
                 ((goal_ff == 2'd1 || goal_ff == 2'd2) ? {1'b0, cfg.rect_width} : 5'd0);
      gy_units = {1'b0, cfg.corner_y} +
                 (goal_ff[1] ? {1'b0, cfg.rect_height} : 5'd0);
      dx_calc  = $signed({2'b00, gx_units, 10'd0}) - $signed({req_pose_x[POS_W-1], req_pose_x});
      dy_calc  = $signed({2'b00, gy_units, 10'd0}) - $signed({req_pose_y[POS_W-1], req_pose_y});
      x0       = $signed({{3{dx_calc[DIFF_W-1]}}, dx_calc, 12'd0});
      y0       = $signed({{3{dy_calc[DIFF_W-1]}}, dy_calc, 12'd0});
      start_hit = (req_pose_x == {2'b00, cfg.corner_x, 10'd0}) &&
                  (req_pose_y == {2'b00, cfg.corner_y, 10'd0}) &&
                  (req_pose_heading == '0);
   end

   // ---------------- one vectoring step
   logic signed [VEC_W-1:0] xs, ys;
   logic signed [ANG_W-1:0] atan_step;

   assign xs        = x_ff >>> cmd.iter;
   assign ys        = y_ff >>> cmd.iter;
   assign atan_step = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_q20(cmd.iter)});

   // ---------------- shared squarer, used in the first four steps
   logic                     sq_phase;
   logic signed [DIFF_W-1:0] mul_op;
   logic signed [2*DIFF_W-1:0] mul_out;

   assign sq_phase = cmd.rotate && (cmd.iter < ITER_W'(4));
   always_comb begin
      unique case (cmd.iter[1:0])
         2'd0:    mul_op = dx_ff;
         2'd1:    mul_op = dy_ff;
         default: mul_op = $signed({2'b00, cfg.position_tolerance});
      endcase
   end
   assign mul_out = mul_op * mul_op;

   // ---------------- heading error
   logic signed [BEAR_W-1:0] bearing;
   logic signed [ANG_W-1:0]  z_round;

   assign z_round = z_ff + ROUND_Q8;
   assign bearing = zero_ff ? '0 : z_round[ANG_W-1:8];

   // ---------------- decision at commit
   logic [HERR_W-1:0]        ah;
   logic signed [HERR_W-1:0] h_wrap;
   logic                     in_tol, pos_turn, reached;
   logic [DIFF_W-1:0]        adx, ady;
   logic [3:0]               lin;
   logic [4:0]               ang;

   always_comb begin
      ah       = h_ff[HERR_W-1] ? HERR_W'(-h_ff) : HERR_W'(h_ff);
      in_tol   = ah < {4'd0, cfg.heading_tolerance};
      h_wrap   = h_ff[HERR_W-1] ? (h_ff + TWO_PI_Q12) : h_ff;
      pos_turn = !h_wrap[HERR_W-1] && (h_wrap <= PI_Q12);
      lin      = in_tol ? cfg.forward_speed : 4'd0;
      if (in_tol) begin
         ang = 5'd0;
      end else if (pos_turn) begin
         ang = {1'b0, cfg.turn_speed};
      end else begin
         ang = 5'd0 - {1'b0, cfg.turn_speed};
      end
      reached  = sq_ff < {{(SQ_W-TOLSQ_W){1'b0}}, tolsq_ff};
      adx      = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      ady      = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
   end

   // Advance or reset goal and start flag on commit
   always_comb begin
      goal_in    = goal_ff;
      started_in = started_ff;
      if (cmd.commit) begin
         if (action_ff) begin
            goal_in    = GOAL_RESET;
            started_in = 1'b0;
         end else begin
            goal_in    = reached ? goal_ff + 2'd1 : goal_ff;
            started_in = started_ff | start_hit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff    <= GOAL_RESET;
         started_ff <= 1'b0;
      end else begin
         goal_ff    <= goal_in;
         started_ff <= started_in;
      end
   end

   // Capture the transaction, then iterate the vector toward the x axis
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         dx_ff        <= dx_calc;
         dy_ff        <= dy_calc;
         ph_ff        <= $signed(req_pose_heading);
         zero_ff      <= (dx_calc == '0) && (dy_calc == '0);
         start_hit_ff <= start_hit;
         if (dx_calc[DIFF_W-1]) begin
            x_ff <= -x0;
            y_ff <= -y0;
            z_ff <= dy_calc[DIFF_W-1] ? -PI_Q20 : PI_Q20;
         end else begin
            x_ff <= x0;
            y_ff <= y0;
            z_ff <= '0;
         end
      end else if (cmd.rotate) begin
         if (!y_ff[VEC_W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + atan_step;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - atan_step;
         end
      end
      if (cmd.angle) begin
         h_ff <= HERR_W'(bearing) - HERR_W'(ph_ff);
      end
   end

   // Squares: dx^2, dy^2 and tolerance^2 stream through one registered product
   always_ff @(posedge clock) begin
      if (sq_phase) begin
         prod_ff <= mul_out[SQ_W-1:0];
         unique case (cmd.iter[1:0])
            2'd1:    sq_ff    <= prod_ff;
            2'd2:    sq_ff    <= sq_ff + prod_ff;
            2'd3:    tolsq_ff <= prod_ff[TOLSQ_W-1:0];
            default: ;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (action_ff) begin
            o_cmd_valid_ff <= 1'b1;
            o_lin_ff       <= '0;
            o_ang_ff       <= '0;
            o_err_valid_ff <= 1'b0;
            o_xerr_ff      <= '0;
            o_yerr_ff      <= '0;
            o_herr_ff      <= '0;
            o_reached_ff   <= 1'b0;
            o_goal_ff      <= GOAL_RESET;
         end else begin
            o_cmd_valid_ff <= started_ff;
            o_lin_ff       <= lin;
            o_ang_ff       <= ang;
            o_err_valid_ff <= 1'b1;
            o_xerr_ff      <= (adx > DIFF_W'(ERR_MAX)) ? ERR_MAX : adx[ERR_W-1:0];
            o_yerr_ff      <= (ady > DIFF_W'(ERR_MAX)) ? ERR_MAX : ady[ERR_W-1:0];
            o_herr_ff      <= (ah > HERR_W'(ERR_MAX)) ? ERR_MAX : ah[ERR_W-1:0];
            o_reached_ff   <= reached;
            o_goal_ff      <= goal_ff;
         end
      end
   end

   assign rsp_tdata = {7'd0, o_goal_ff, o_reached_ff, o_herr_ff, o_yerr_ff, o_xerr_ff,
                       o_ang_ff, o_lin_ff};
   assign rsp_tuser = {o_err_valid_ff, o_cmd_valid_ff};

endmodule

// File: hw/rtl/bang_bang_waypoint_follower.sv
// Top level of the bang-bang waypoint follower.
// Each pose transaction steers toward the current corner of a configured rectangle
// (corners visited 1, 2, 3, 0, 1, ...) and returns one result transaction: speed
// command, absolute x, y and heading errors, and whether the goal was reached. A pose
// passes a load state, ANGLE_ITERATIONS atan2 vectoring steps in the single
// shared rotation unit, a state that forms the heading error and a commit state; a
// new pose is accepted only after the last one is committed. One shared multiplier
// computes the squared distance during the first vectoring steps. A restart goes
// from load straight to commit. Commit waits while a previous result is still held
// in the output register. Pose results flag commands valid only after a pose has
// once matched the start corner with zero heading. Registers must be written only
// while the block is idle; the block itself does not enforce this.
module bang_bang_waypoint_follower
   import bbwf_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // pose_x [15:0], pose_y [31:16], pose_heading [46:32], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action (0 pose sample, 1 restart)
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // linear_speed [3:0], angular_speed [8:4], x_error [23:9], y_error [38:24],
   // heading_error [53:39], goal_reached [54], goal_number [56:55], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // command_valid [0], error_valid [1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   cmd_type cmd;

   bbwf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bbwf_ctrl #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .restart_req (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd)
   );

   bbwf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_action       (req_tuser),
      .req_pose_x       (req_tdata[15:0]),
      .req_pose_y       (req_tdata[31:16]),
      .req_pose_heading (req_tdata[46:32]),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule
